@@ sv/cmf_pkg.sv @@
package cmf_pkg;

  // Ring geometry
  localparam int DEPTH = 8;
  localparam int IDX_W = $clog2(DEPTH);

  // Message field widths
  localparam int ID_W   = 11;
  localparam int LEN_W  = 4;
  localparam int PAY_W  = 64;
  localparam int HDR_W  = 32;
  localparam int SLOT_W = ID_W + LEN_W + PAY_W;

  // Header field positions
  localparam int ID_LSB  = 18;
  localparam int LEN_LSB = 16;

  // Stream widths
  localparam int IN_DATA_W  = 2 * HDR_W + PAY_W;
  localparam int OUT_USED_W = 3 + ID_W + LEN_W + PAY_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // Command selector carried in tuser
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic take;  // request accepted this cycle
    logic fill;  // load popped slot from RAM read data
  } cmf_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic pop_hit;  // current request is a pop on a non-empty ring
  } cmf_stat_t;

  // Advance a ring index with wrap
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

@@ sv/cmf_ram.sv @@
module cmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cmf_ctrl.sv @@
module cmf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  input  cmf_pkg::cmf_stat_t  stat_i,
  output cmf_pkg::cmf_ctrl_t  ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOAD = 2'b10
  } cmf_state_e;

  cmf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       take;

  // Output register is free when empty or drained this cycle
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  assign ctrl_o.take = take;
  assign ctrl_o.fill = (state_q == ST_LOAD);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && stat_i.pop_hit) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if ((take && !stat_i.pop_hit) || (state_q == ST_LOAD)) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

`ifndef SYNTHESIS
  // A pop that waits on RAM data never finds a result still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !out_valid_q)
    else $error("output register busy during RAM load");

  // A pop on a non-empty ring goes through the load cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && stat_i.pop_hit) |=> (state_q == ST_LOAD))
    else $error("pop hit did not enter load state");

  // The load cycle always presents its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("load cycle did not produce a result");
`endif

endmodule

@@ sv/cmf_dp.sv @@
module cmf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cmf_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                              s_axis_tuser_i,
  output logic [cmf_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  input  cmf_pkg::cmf_ctrl_t                ctrl_i,
  output cmf_pkg::cmf_stat_t                stat_o
);

  logic [cmf_pkg::IDX_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [cmf_pkg::IDX_W-1:0]  wr_nxt, rd_nxt;
  logic                       full, empty, is_pop;
  logic [cmf_pkg::HDR_W-1:0]  hdr0, hdr1;
  logic [cmf_pkg::PAY_W-1:0]  pay_in;
  logic [cmf_pkg::SLOT_W-1:0] slot_wdata, slot_rdata;
  logic                       ram_we, ram_re;

  logic                       acc_q, acc_d, dlv_q, dlv_d, mail_q, mail_d;
  logic [cmf_pkg::ID_W-1:0]   id_q, id_d;
  logic [cmf_pkg::LEN_W-1:0]  len_q, len_d;
  logic [cmf_pkg::PAY_W-1:0]  pay_q, pay_d;

  // Unpack request
  assign hdr0   = s_axis_tdata_i[cmf_pkg::HDR_W-1:0];
  assign hdr1   = s_axis_tdata_i[2*cmf_pkg::HDR_W-1:cmf_pkg::HDR_W];
  assign pay_in = s_axis_tdata_i[cmf_pkg::IN_DATA_W-1:2*cmf_pkg::HDR_W];
  assign is_pop = (s_axis_tuser_i == cmf_pkg::CMD_POP);

  // Ring occupancy
  assign wr_nxt = cmf_pkg::ring_next(wr_q);
  assign rd_nxt = cmf_pkg::ring_next(rd_q);
  assign full   = (wr_nxt == rd_q);
  assign empty  = (wr_q == rd_q);

  assign stat_o.pop_hit = is_pop && !empty;

  // Slot word: id lowest, then length, then payload
  assign slot_wdata = {pay_in,
                       hdr1[cmf_pkg::LEN_LSB +: cmf_pkg::LEN_W],
                       hdr0[cmf_pkg::ID_LSB +: cmf_pkg::ID_W]};
  assign ram_we = ctrl_i.take && !is_pop;
  assign ram_re = ctrl_i.take && is_pop && !empty;

  cmf_ram #(
    .WIDTH (cmf_pkg::SLOT_W),
    .DEPTH (cmf_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (slot_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_q),
    .rdata_o (slot_rdata)
  );

  // Index and result register updates
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    acc_d  = acc_q;
    dlv_d  = dlv_q;
    mail_d = mail_q;
    id_d   = id_q;
    len_d  = len_q;
    pay_d  = pay_q;
    if (ctrl_i.take) begin
      id_d  = '0;
      len_d = '0;
      pay_d = '0;
      if (!is_pop) begin
        wr_d   = full ? wr_q : wr_nxt;
        acc_d  = !full;
        dlv_d  = 1'b0;
        mail_d = (wr_d != rd_q);
      end else begin
        rd_d   = empty ? rd_q : rd_nxt;
        acc_d  = 1'b0;
        dlv_d  = !empty;
        mail_d = (rd_d != wr_q);
      end
    end else if (ctrl_i.fill) begin
      id_d  = slot_rdata[cmf_pkg::ID_W-1:0];
      len_d = slot_rdata[cmf_pkg::ID_W +: cmf_pkg::LEN_W];
      pay_d = slot_rdata[cmf_pkg::ID_W+cmf_pkg::LEN_W +: cmf_pkg::PAY_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    dlv_q  <= dlv_d;
    mail_q <= mail_d;
    id_q   <= id_d;
    len_q  <= len_d;
    pay_q  <= pay_d;
  end

  assign m_axis_tdata_o = {{cmf_pkg::OUT_PAD_W{1'b0}}, mail_q, pay_q, len_q, id_q,
                           dlv_q, acc_q};

endmodule

@@ sv/can_rx_message_fifo.sv @@
// Channel  Dir  Ports          Contents
// s_axis   in   tdata/tuser    request: push element or pop oldest message
// m_axis   out  tdata          one result per request
//
// A pop that finds a message passes through the load state for the registered
// read of the slot RAM; a push or a pop on an empty ring does not.
// The single output register lets a new request in while its result is taken.
// Reset (asynchronous, active low) clears both ring indices; slot contents
// stay undefined until written and need no clearing pass.
// A stalled output holds its result and blocks new requests.
module can_rx_message_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: header_word0 [31:0], header_word1 [63:32], payload_in [127:64]
  input  logic [cmf_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: cmd [0]
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: accepted [0], delivered [1], msg_id [12:2], msg_length [16:13],
  //        payload_out [80:17], mail_waiting [81], zero pad [87:82]
  output logic [cmf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);

  cmf_pkg::cmf_ctrl_t ctrl;
  cmf_pkg::cmf_stat_t stat;

  // Handshake sequencing
  cmf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .stat_i          (stat),
    .ctrl_o          (ctrl)
  );

  // Ring indices, slot RAM and result register
  cmf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .ctrl_i         (ctrl),
    .stat_o         (stat)
  );

endmodule

@@ tb/tb_can_rx_message_fifo.sv @@
`timescale 1ns / 1ps

module tb_can_rx_message_fifo;

  localparam int NUM_RAND_REQS = 680;
  localparam int MAX_IDLE      = 18;
  localparam int LONG_HOLD     = 80;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int TAIL_CYCLES   = 10;

  // One request as offered on the slave side
  typedef struct {
    logic                      cmd;
    logic [cmf_pkg::HDR_W-1:0] word0;
    logic [cmf_pkg::HDR_W-1:0] word1;
    logic [cmf_pkg::PAY_W-1:0] payload;
    int                        gap;
    bit                        drain;  // hold the request until all results are back
  } can_req_t;

  // One result as seen on the master side
  typedef struct packed {
    logic                      accepted;
    logic                      delivered;
    logic [cmf_pkg::ID_W-1:0]  id;
    logic [cmf_pkg::LEN_W-1:0] len;
    logic [cmf_pkg::PAY_W-1:0] payload;
    logic                      mail;
  } rx_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic [cmf_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tuser = cmf_pkg::CMD_PUSH;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [cmf_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;

  can_rx_message_fifo u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  always #10 clk_i = ~clk_i;

  // Mailbox shadow state
  logic [cmf_pkg::ID_W-1:0]  mbox_id  [cmf_pkg::DEPTH];
  logic [cmf_pkg::LEN_W-1:0] mbox_len [cmf_pkg::DEPTH];
  logic [cmf_pkg::PAY_W-1:0] mbox_pay [cmf_pkg::DEPTH];
  int                        mbox_wr = 0;
  int                        mbox_rd = 0;

  can_req_t   pending_reqs[$];
  rx_result_t expected_results[$];
  can_req_t   cur_req;
  bit         have_req = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         results_seen = 0;
  int         errors = 0;
  int         cycles = 0;
  int         n_push_ok = 0, n_push_drop = 0, n_pop_ok = 0, n_pop_empty = 0;

  // Expected result of one request; updates the shadow ring
  function automatic rx_result_t mailbox_predict(can_req_t r);
    rx_result_t res;
    int         nxt;
    res = '0;
    if (r.cmd == cmf_pkg::CMD_PUSH) begin
      // slot is written even when full; it is outside the readable window
      mbox_id[mbox_wr]  = r.word0[cmf_pkg::ID_LSB +: cmf_pkg::ID_W];
      mbox_len[mbox_wr] = r.word1[cmf_pkg::LEN_LSB +: cmf_pkg::LEN_W];
      mbox_pay[mbox_wr] = r.payload;
      nxt = (mbox_wr + 1) % cmf_pkg::DEPTH;
      if (nxt != mbox_rd) begin
        mbox_wr = nxt;
        res.accepted = 1'b1;
      end
    end else if (mbox_rd != mbox_wr) begin
      res.id        = mbox_id[mbox_rd];
      res.len       = mbox_len[mbox_rd];
      res.payload   = mbox_pay[mbox_rd];
      res.delivered = 1'b1;
      mbox_rd = (mbox_rd + 1) % cmf_pkg::DEPTH;
    end
    res.mail = (mbox_rd != mbox_wr);
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Idle count per request: phases of heavy gaps, no gaps, and sparse gaps
  function automatic int draw_idle(int n);
    case ((n / 50) % 3)
      0:       return $urandom_range(0, MAX_IDLE);
      1:       return 0;
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
    endcase
  endfunction

  task automatic add_req(logic cmd, logic [31:0] w0, logic [31:0] w1, logic [63:0] pay,
                         bit drain = 1'b0);
    can_req_t r;
    r.cmd     = cmd;
    r.word0   = w0;
    r.word1   = w1;
    r.payload = pay;
    r.gap     = draw_idle(pending_reqs.size());
    r.drain   = drain;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(logic cmd);
    logic [31:0] w0;
    logic [31:0] w1;
    w0 = $urandom;
    w1 = $urandom;
    // push identifier and length codes to their extremes now and then
    case ($urandom_range(0, 7))
      0: begin
        w0[cmf_pkg::ID_LSB +: cmf_pkg::ID_W]   = '0;
        w1[cmf_pkg::LEN_LSB +: cmf_pkg::LEN_W] = '0;
      end
      1: begin
        w0[cmf_pkg::ID_LSB +: cmf_pkg::ID_W]   = '1;
        w1[cmf_pkg::LEN_LSB +: cmf_pkg::LEN_W] = '1;
      end
      default: ;
    endcase
    add_req(cmd, w0, w1, {$urandom, $urandom}, $urandom_range(0, 99) == 0);
  endtask

  // Request driver
  always @(posedge clk_i) begin : driver
    logic next_valid;
    if (rst_ni) begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        // tally dropped pushes and empty pops against the shadow ring before it moves
        if (cur_req.cmd == cmf_pkg::CMD_PUSH &&
            ((mbox_wr + 1) % cmf_pkg::DEPTH) == mbox_rd) n_push_drop++;
        if (cur_req.cmd == cmf_pkg::CMD_POP && mbox_rd == mbox_wr) n_pop_empty++;
        expected_results.push_back(mailbox_predict(cur_req));
        next_valid = 1'b0;
        have_req   = 1'b0;
      end
      if (!have_req && pending_reqs.size() > 0) begin
        cur_req  = pending_reqs.pop_front();
        gap_left = cur_req.gap;
        have_req = 1'b1;
      end
      if (have_req && !next_valid && !(cur_req.drain && expected_results.size() > 0)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          s_tdata    <= {cur_req.payload, cur_req.word1, cur_req.word0};
          s_tuser    <= cur_req.cmd;
          next_valid = 1'b1;
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i) begin : monitor
    rx_result_t got;
    rx_result_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.accepted  = m_tdata[0];
        got.delivered = m_tdata[1];
        got.id        = m_tdata[12:2];
        got.len       = m_tdata[16:13];
        got.payload   = m_tdata[80:17];
        got.mail      = m_tdata[81];
        if (expected_results.size() == 0) begin
          $error("unexpected result 0x%0h with no request pending", m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(got.accepted));
          check_field("delivered", 64'(want.delivered), 64'(got.delivered));
          check_field("msg_id", 64'(want.id), 64'(got.id));
          check_field("msg_length", 64'(want.len), 64'(got.len));
          check_field("payload_out", want.payload, got.payload);
          check_field("mail_waiting", 64'(want.mail), 64'(got.mail));
          if (want.accepted) n_push_ok++;
          else if (want.delivered) n_pop_ok++;
        end
        results_seen++;
        // long hold-offs let the block back up and stall its input
        if (results_seen == 40 || results_seen == 450) begin
          stall_left = LONG_HOLD;
        end else begin
          case ((results_seen / 60) % 3)
            0:       stall_left = $urandom_range(0, MAX_IDLE);
            1:       stall_left = 0;
            default: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
          endcase
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int len;
    int kind;
    // directed: empty pop, header and payload extremes, fill, overflow, drain
    add_req(cmf_pkg::CMD_POP, '1, '1, '1);
    add_req(cmf_pkg::CMD_PUSH, '0, '0, '0);
    add_req(cmf_pkg::CMD_PUSH, '1, '1, '1);
    add_req(cmf_pkg::CMD_PUSH, 32'h1FFC_0000, 32'h000F_0000, 64'hAAAA_AAAA_AAAA_AAAA);
    add_req(cmf_pkg::CMD_PUSH, ~32'h1FFC_0000, ~32'h000F_0000, 64'h5555_5555_5555_5555);
    add_req(cmf_pkg::CMD_PUSH, 32'h0004_0000, 32'h0001_0000, 64'h8000_0000_0000_0001);
    add_req(cmf_pkg::CMD_PUSH, 32'h1000_0000, 32'h0008_0000, 64'h0123_4567_89AB_CDEF);
    add_req(cmf_pkg::CMD_PUSH, 32'hE003_FFFF, 32'hFFF0_FFFF, 64'hFEDC_BA98_7654_3210);
    add_req(cmf_pkg::CMD_PUSH, 32'h1554_0000, 32'h000A_0000, 64'h00FF_00FF_00FF_00FF);
    add_req(cmf_pkg::CMD_PUSH, 32'h0AA8_0000, 32'h0005_0000, 64'hFF00_FF00_FF00_FF00);
    for (int i = 0; i < cmf_pkg::DEPTH - 1; i++)
      add_req(cmf_pkg::CMD_POP, $urandom, $urandom, '0, i == 0);
    add_req(cmf_pkg::CMD_POP, '0, '0, '0);
    add_req(cmf_pkg::CMD_PUSH, $urandom, $urandom, {$urandom, $urandom});
    add_req(cmf_pkg::CMD_POP, '1, '0, '1);
    // random bursts: long pushes reach full, long pops reach empty
    n = 0;
    while (n < NUM_RAND_REQS) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if (kind < 4) add_random(cmf_pkg::CMD_PUSH);
        else if (kind < 8) add_random(cmf_pkg::CMD_POP);
        else add_random(1'($urandom_range(0, 1)));
      end
      n += len;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || have_req || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("checked %0d results: %0d pushes stored, %0d dropped on full ring",
             results_seen, n_push_ok, n_push_drop);
    $display("%0d pops delivered, %0d pops on empty ring, %0d cycles",
             n_pop_ok, n_pop_empty, cycles);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
